/* rtl/lrupr_pkg.sv */
`default_nettype none

package lrupr_pkg;

    // Field widths of the stream beats and the config register
    localparam int PAGE_FIELD_W  = 16;
    localparam int FRAME_FIELD_W = 3;
    localparam int CNT_W         = 32;
    localparam int CFG_W         = 4;
    localparam int IN_DATA_W     = 24;   // 17 bits of fields, padded to whole bytes
    localparam int OUT_DATA_W    = 88;   // 85 bits of fields, padded to whole bytes

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Outcome of one lookup: exactly one flag is set
    typedef struct packed {
        logic hit;     // page resident
        logic fill;    // miss, an empty active frame is taken
        logic evict;   // miss, least recently used active frame is replaced
    } lookup_flags_t;

endpackage

`default_nettype wire

/* rtl/lrupr_lookup.sv */
`default_nettype none

// Parallel tag compare, free-frame pick and LRU victim pick over the active frames.
module lrupr_lookup #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic [FRAMES-1:0]                 active,
    input  wire logic [FRAMES-1:0]                 valid,
    input  wire logic [FRAMES-1:0][PAGE_BITS-1:0]  pages,
    input  wire logic [FRAMES-1:0][((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] ranks,
    input  wire logic [PAGE_BITS-1:0]              page,
    output lrupr_pkg::lookup_flags_t               flags,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame,
    output logic [PAGE_BITS-1:0]                   ev_page
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] free;
    logic [FRAMES-1:0] oldest;
    logic [IW-1:0]     hit_idx;
    logic [IW-1:0]     free_idx;
    logic [IW-1:0]     old_idx;

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            match[i] = active[i] && valid[i] && (pages[i] == page);
            free[i]  = active[i] && !valid[i];
        end
    end

    // Highest rank wins; on equal ranks the higher frame index wins
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            oldest[i] = active[i];
            for (int j = 0; j < FRAMES; j++)
            begin
                if (j != i && active[j])
                begin
                    if (j < i)
                    begin
                        if (ranks[i] < ranks[j])
                            oldest[i] = 1'b0;
                    end
                    else if (ranks[i] <= ranks[j])
                    begin
                        oldest[i] = 1'b0;
                    end
                end
            end
        end
    end

    // Lowest index first
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        old_idx  = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
                hit_idx = IW'(i);
            if (free[i])
                free_idx = IW'(i);
            if (oldest[i])
                old_idx = IW'(i);
        end
    end

    always_comb
    begin
        flags.hit   = |match;
        flags.fill  = !(|match) && (|free);
        flags.evict = !(|match) && !(|free);
        if (flags.hit)
            frame = hit_idx;
        else if (flags.fill)
            frame = free_idx;
        else
            frame = old_idx;
        ev_page = flags.evict ? pages[old_idx] : '0;
    end

endmodule

`default_nettype wire

/* rtl/lrupr_table.sv */
`default_nettype none

// Frame table state: page tags, valid bits and recency ranks (0 = most recent).
// Valid and rank outputs are the view seen by the current reference, already cleared on restart.
module lrupr_table #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              upd,
    input  wire logic                              restart,
    input  wire lrupr_pkg::lookup_flags_t          flags,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame,
    input  wire logic [PAGE_BITS-1:0]              page,
    output logic [FRAMES-1:0]                      valid,
    output logic [FRAMES-1:0][PAGE_BITS-1:0]       pages,
    output logic [FRAMES-1:0][((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] ranks
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RW = IW;

    logic [FRAMES-1:0]                 valid_reg;
    logic [FRAMES-1:0]                 valid_next;
    logic [FRAMES-1:0][RW-1:0]         rank_reg;
    logic [FRAMES-1:0][RW-1:0]         rank_next;
    logic [FRAMES-1:0][PAGE_BITS-1:0]  page_reg;
    logic [RW-1:0]                     rank_f;

    assign pages = page_reg;

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            valid[i] = restart ? 1'b0 : valid_reg[i];
            ranks[i] = restart ? '0 : rank_reg[i];
        end
        rank_f = ranks[frame];
    end

    // Fill ages every valid frame; hit and evict age only the frames younger
    // than the touched one. The touched frame becomes rank 0.
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            valid_next[i] = valid[i] || (flags.fill && (frame == IW'(i)));
            if (frame == IW'(i))
                rank_next[i] = '0;
            else if (valid[i] && (flags.fill || (ranks[i] < rank_f)))
                rank_next[i] = ranks[i] + 1'b1;
            else
                rank_next[i] = ranks[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rank_reg  <= '0;
        end
        else if (upd)
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd && !flags.hit)
            page_reg[frame] <= page;
    end

endmodule

`default_nettype wire

/* rtl/lru_page_replacement_top.sv */
`default_nettype none

// Fully associative page-frame table with least-recently-used replacement.
// Each input beat references one page; the result beat tells hit or fault, the
// frame that holds the page afterwards, the evicted page (zero if none) and the
// saturating hit and fault counts. A fault fills the lowest-numbered empty active
// frame, else replaces the least recently used active frame. Setting restart in a
// beat clears the table and both counters before that reference is handled.
// cfg_wdata sets the number of active frames (0 acts as 1, above FRAMES acts as
// FRAMES); frames above the count keep their contents but are neither searched
// nor replaced. Write it only while no beat is in flight.
// Rate: one reference per clock while m_axis_tready is not held low; a result
// beat passes the input register, then the result register. The tag compare
// and the rank update in the frame table sit between the two.
module lru_page_replacement_top #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // config: number of active frames
    input  wire logic                                  cfg_we,
    input  wire logic [lrupr_pkg::CFG_W-1:0]           cfg_wdata,
    // input beats
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [15:0] page_number, [16] restart, rest zero
    input  wire logic [lrupr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // result beats
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [0] hit, [3:1] frame_index, [4] evicted_valid, [20:5] evicted_page,
    // [52:21] hit_count, [84:53] fault_count, rest zero
    output logic [lrupr_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW = lrupr_pkg::PAGE_FIELD_W;
    localparam int FW = lrupr_pkg::FRAME_FIELD_W;
    localparam int CW = lrupr_pkg::CNT_W;

    // Active-frame mask, decoded at config write time
    logic [FRAMES-1:0]  active_reg;
    logic [FRAMES-1:0]  active_next;

    // Input register
    logic               s1_valid_reg;
    logic [PW-1:0]      s1_page_reg;
    logic               s1_restart_reg;

    // Counters
    logic [CW-1:0]      hits_reg;
    logic [CW-1:0]      faults_reg;
    logic [CW-1:0]      hits_next;
    logic [CW-1:0]      faults_next;

    // Result register
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [FW-1:0]      out_frame_reg;
    logic               out_ev_valid_reg;
    logic [PW-1:0]      out_ev_page_reg;
    logic [CW-1:0]      out_hit_count_reg;
    logic [CW-1:0]      out_fault_count_reg;

    logic               adv;
    logic               s1_fire;

    logic [PAGE_BITS-1:0]                           page;
    lrupr_pkg::lookup_flags_t                       flags;
    logic [IW-1:0]                                  frame;
    logic [PAGE_BITS-1:0]                           ev_page;
    logic [FRAMES-1:0]                              valid;
    logic [FRAMES-1:0][PAGE_BITS-1:0]               pages;
    logic [FRAMES-1:0][IW-1:0]                      ranks;
    logic [IW+FW-1:0]                               frame_ext;
    logic [PAGE_BITS+PW-1:0]                        ev_page_ext;
    logic [FRAMES-1:0]                              mru_vec;

    // Result stage moves when empty or drained; input stage moves with it
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && adv;
    assign s_axis_tready = !s1_valid_reg || adv;

    assign page = PAGE_BITS'(s1_page_reg);

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
            active_next[i] = (i == 0) || (i < int'(cfg_wdata));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '1;
        else if (cfg_we)
            active_reg <= active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_page_reg    <= s_axis_tdata[PW-1:0];
            s1_restart_reg <= s_axis_tdata[PW];
        end
    end

    lrupr_lookup #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_lookup (
        .active  (active_reg),
        .valid   (valid),
        .pages   (pages),
        .ranks   (ranks),
        .page    (page),
        .flags   (flags),
        .frame   (frame),
        .ev_page (ev_page)
    );

    lrupr_table #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (s1_fire),
        .restart (s1_restart_reg),
        .flags   (flags),
        .frame   (frame),
        .page    (page),
        .valid   (valid),
        .pages   (pages),
        .ranks   (ranks)
    );

    // Saturating counters, cleared first on restart
    always_comb
    begin
        hits_next   = s1_restart_reg ? '0 : hits_reg;
        faults_next = s1_restart_reg ? '0 : faults_reg;
        if (flags.hit)
        begin
            if (hits_next != lrupr_pkg::CNT_MAX)
                hits_next = hits_next + 1'b1;
        end
        else if (faults_next != lrupr_pkg::CNT_MAX)
        begin
            faults_next = faults_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg   <= '0;
            faults_reg <= '0;
        end
        else if (s1_fire)
        begin
            hits_reg   <= hits_next;
            faults_reg <= faults_next;
        end
    end

    // Frame index and evicted page are cut or zero-extended to the field widths
    assign frame_ext   = {{FW{1'b0}}, frame};
    assign ev_page_ext = {{PW{1'b0}}, ev_page};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_hit_reg         <= flags.hit;
            out_frame_reg       <= frame_ext[FW-1:0];
            out_ev_valid_reg    <= flags.evict;
            out_ev_page_reg     <= ev_page_ext[PW-1:0];
            out_hit_count_reg   <= hits_next;
            out_fault_count_reg <= faults_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(lrupr_pkg::OUT_DATA_W - (2 * CW + PW + FW + 2)){1'b0}},
        out_fault_count_reg,
        out_hit_count_reg,
        out_ev_page_reg,
        out_ev_valid_reg,
        out_frame_reg,
        out_hit_reg
    };

    // Valid frames that claim most-recent rank
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
            mru_vec[i] = valid[i] && (ranks[i] == '0);
    end

`ifndef SYNTHESIS
    // Ranks of valid frames are distinct: at most one is most recent
    a_single_mru: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(mru_vec))
        else $error("more than one most-recent frame");

    // A result is never both a hit and an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_ev_valid_reg))
        else $error("hit with eviction");

    // No eviction reports page zero
    a_ev_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ev_valid_reg) |-> (out_ev_page_reg == '0))
        else $error("evicted page nonzero without eviction");

    // After a restart beat the counters hold exactly one event
    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_restart_reg) |=>
            ((33'(out_hit_count_reg) + 33'(out_fault_count_reg)) == 33'd1))
        else $error("counters not reset by restart");
`endif

endmodule

`default_nettype wire
